### src/block_buffer_cache_tags_defines.svh
// assertion macros for the buffer cache tag store
`ifndef BLOCK_BUFFER_CACHE_TAGS_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_TAGS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbct check failed");

// next-cycle implication, checked outside reset
`define BBCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbct check failed");

`endif

### src/bbct_pkg.sv
// types and constants shared by the buffer cache tag store
package bbct_pkg;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBUF = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] now_tick;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] result_entry;
    logic       hit;
    logic       needs_read;
  } out_t;

  // running search record that walks down the cell row
  typedef struct packed {
    logic        vld;
    logic        found;
    logic [7:0]  hit_idx;
    logic [7:0]  hit_cnt;
    logic        hit_loaded;
    logic        have;
    logic [7:0]  best_idx;
    logic [31:0] best_tick;
  } scan_t;

  typedef enum logic [1:0] {
    CMT_HIT,
    CMT_FILL,
    CMT_UP,
    CMT_DOWN
  } cmt_kind_t;

  // update broadcast to every cell, taken by the addressed one
  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    cmt_kind_t   kind;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [31:0] tick;
  } cmt_t;

endpackage

### src/bbct_cell.sv
// one buffer entry: tag, count and fill tick plus one stage of the search row
module bbct_cell import bbct_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  req_dev,
  input  logic [31:0] req_blk,
  input  scan_t       scan_i,
  output scan_t       scan_o,
  input  cmt_t        cmt,
  output logic [7:0]  count_o
);

  localparam logic [7:0] MY_IDX = 8'(CELL_IDX);

  logic        in_use_r, in_use_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [31:0] blk_r, blk_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        loaded_r, loaded_nxt;
  logic [31:0] tick_r, tick_nxt;
  scan_t       scan_r, scan_nxt;
  logic [7:0]  cnt_up;
  logic [7:0]  cnt_dn;

  assign cnt_up  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 8'd1;
  assign cnt_dn  = (cnt_r == 8'd0) ? cnt_r : cnt_r - 8'd1;
  assign count_o = cnt_r;
  assign scan_o  = scan_r;

  // search step
  always_comb begin
    scan_nxt = scan_i;
    if (scan_i.vld && !scan_i.found && in_use_r && dev_r == req_dev && blk_r == req_blk) begin
      scan_nxt.found      = 1'b1;
      scan_nxt.hit_idx    = MY_IDX;
      scan_nxt.hit_cnt    = cnt_r;
      scan_nxt.hit_loaded = loaded_r;
    end
    if (scan_i.vld && cnt_r == 8'd0 && (!scan_i.have || tick_r < scan_i.best_tick)) begin
      scan_nxt.have      = 1'b1;
      scan_nxt.best_idx  = MY_IDX;
      scan_nxt.best_tick = tick_r;
    end
  end

  // entry update
  always_comb begin
    in_use_nxt = in_use_r;
    dev_nxt    = dev_r;
    blk_nxt    = blk_r;
    cnt_nxt    = cnt_r;
    loaded_nxt = loaded_r;
    tick_nxt   = tick_r;
    if (cmt.en && cmt.idx == MY_IDX) begin
      case (cmt.kind)
        CMT_HIT: begin
          cnt_nxt    = cnt_up;
          loaded_nxt = 1'b1;
        end
        CMT_FILL: begin
          in_use_nxt = 1'b1;
          dev_nxt    = cmt.dev;
          blk_nxt    = cmt.blk;
          cnt_nxt    = 8'd1;
          loaded_nxt = 1'b1;
          tick_nxt   = cmt.tick;
        end
        CMT_UP:   cnt_nxt = cnt_up;
        CMT_DOWN: cnt_nxt = cnt_dn;
        default:  cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      dev_r    <= '0;
      blk_r    <= '0;
      cnt_r    <= '0;
      loaded_r <= 1'b0;
      tick_r   <= '0;
      scan_r   <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      dev_r    <= dev_nxt;
      blk_r    <= blk_nxt;
      cnt_r    <= cnt_nxt;
      loaded_r <= loaded_nxt;
      tick_r   <= tick_nxt;
      scan_r   <= scan_nxt;
    end
  end

endmodule

### src/block_buffer_cache_tags.sv
// top level of the buffer cache tag store: control, entry row and result register
//
//   channel   ports                             payload
//   request   in_valid  / in_stall  / in_data   in_t  (op, device, block, entry, tick)
//   result    out_valid / out_stall / out_data  out_t (status, entry, hit, needs_read)
//
// a get is answered once the search record has stepped through the whole row: the record steps
// through one entry cell a cycle; no new transaction is taken while the get is searching, so
// gets do not overlap
// release, pin and unpin: the count is read and updated at acceptance
// reset (rst_n low, synchronous) clears every entry and all control state at once
// a stalled result is held in the output register and holds off the next transaction
`include "block_buffer_cache_tags_defines.svh"

module block_buffer_cache_tags import bbct_pkg::*; #(
  parameter int NUM_ENTRIES = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int         IDX_W   = $clog2(NUM_ENTRIES);
  localparam logic [8:0] NUM_W9  = 9'(NUM_ENTRIES);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t      state_r, state_nxt;
  logic        inject_r, inject_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;
  logic [7:0]  req_dev_r, req_dev_nxt;
  logic [31:0] req_blk_r, req_blk_nxt;
  logic [31:0] req_tick_r, req_tick_nxt;

  logic        accept;
  logic        in_range;
  logic [IDX_W-1:0] idx_sel;
  logic [7:0]  cnt_sel;
  cmt_t        cmt;
  scan_t       scan_w [NUM_ENTRIES+1];
  logic [7:0]  cnt_q  [NUM_ENTRIES];
  scan_t       last;

  // a new transaction waits while a get is searching or a result sits stalled
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // head of the row: empty search record, live only on the cycle after a get is taken
  always_comb begin
    scan_w[0]     = '0;
    scan_w[0].vld = inject_r;
  end
  assign last = scan_w[NUM_ENTRIES];

  genvar g;
  generate
    for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
      bbct_cell #(
        .CELL_IDX(g)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_dev (req_dev_r),
        .req_blk (req_blk_r),
        .scan_i  (scan_w[g]),
        .scan_o  (scan_w[g+1]),
        .cmt     (cmt),
        .count_o (cnt_q[g])
      );
    end
  endgenerate

  // direct count access for release, pin and unpin
  assign in_range = {4'b0, in_data.entry_index} < NUM_W9;
  assign idx_sel  = IDX_W'(in_data.entry_index);
  assign cnt_sel  = cnt_q[idx_sel];

  always_comb begin
    state_nxt     = state_r;
    inject_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    req_dev_nxt   = req_dev_r;
    req_blk_nxt   = req_blk_r;
    req_tick_nxt  = req_tick_r;
    cmt           = '0;
    cmt.dev       = req_dev_r;
    cmt.blk       = req_blk_r;
    cmt.tick      = req_tick_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_GET) begin
            // latch the tag and start the search
            req_dev_nxt  = in_data.device;
            req_blk_nxt  = in_data.block_number;
            req_tick_nxt = in_data.now_tick;
            inject_nxt   = 1'b1;
            state_nxt    = S_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            if (!in_range) begin
              out_nxt.status = ST_COUNT;
            end else begin
              cmt.en  = 1'b1;
              cmt.idx = 8'(in_data.entry_index);
              case (in_data.op)
                OP_PIN: begin
                  cmt.kind       = CMT_UP;
                  out_nxt.status = (cnt_sel == COUNT_MAX) ? ST_COUNT : ST_OK;
                end
                OP_RELEASE, OP_UNPIN: begin
                  cmt.kind       = CMT_DOWN;
                  out_nxt.status = (cnt_sel == 8'd0) ? ST_COUNT : ST_OK;
                end
                default: begin
                  cmt.en = 1'b0;
                end
              endcase
            end
          end
        end
      end
      S_SCAN: begin
        // search record leaves the last cell: decide and write back
        if (last.vld) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          state_nxt     = S_IDLE;
          if (last.found) begin
            cmt.en               = 1'b1;
            cmt.idx              = last.hit_idx;
            cmt.kind             = CMT_HIT;
            out_nxt.status       = (last.hit_cnt == COUNT_MAX) ? ST_COUNT : ST_OK;
            out_nxt.result_entry = last.hit_idx[4:0];
            out_nxt.hit          = 1'b1;
            out_nxt.needs_read   = !last.hit_loaded;
          end else if (last.have) begin
            // refill the oldest free entry
            cmt.en               = 1'b1;
            cmt.idx              = last.best_idx;
            cmt.kind             = CMT_FILL;
            out_nxt.result_entry = last.best_idx[4:0];
            out_nxt.needs_read   = 1'b1;
          end else begin
            out_nxt.status = ST_NOBUF;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inject_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inject_r    <= inject_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      req_dev_r   <= req_dev_nxt;
      req_blk_r   <= req_blk_nxt;
      req_tick_r  <= req_tick_nxt;
    end
  end

  // a search record only reaches the end of the row while a get is in flight
  `BBCT_ASSERT_SAME(a_scan_in_flight, last.vld, state_r == S_SCAN)
  // a count operation answers in the very next cycle
  `BBCT_ASSERT_NEXT(a_count_op_answers, accept && in_data.op != OP_GET, out_valid_r)
  // entries change only on a count operation or at the end of a search
  `BBCT_ASSERT_SAME(a_commit_source, cmt.en, accept || (state_r == S_SCAN && last.vld))
  // the result register is empty when the search starts
  `BBCT_ASSERT_SAME(a_scan_out_empty, inject_r, state_r == S_SCAN && !out_valid_r)

endmodule

### tb/block_buffer_cache_tags_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the buffer cache tag store
module block_buffer_cache_tags_tb;
  import bbct_pkg::*;

  localparam int ENTRIES      = 32;
  localparam int RANDOM_ITEMS = 1250;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES  = 400;
  // a get walks every entry once, so two full scans cover any tail
  localparam int TAIL_CYCLES  = 2 * ENTRIES + 8;
  // wide margin over the slowest legal run
  localparam int CYCLE_LIMIT  = 600000;

  // mirror of the tag store plus the queue of results still owed by the block
  class tag_store_scoreboard;
    bit        in_use   [ENTRIES];
    bit [7:0]  tag_dev  [ENTRIES];
    bit [31:0] tag_blk  [ENTRIES];
    bit [7:0]  refs     [ENTRIES];
    bit        loaded   [ENTRIES];
    bit [31:0] filled_at[ENTRIES];
    out_t      owed_q[$];
    int        errors;

    function logic [1:0] count_up(int e);
      if (refs[e] == COUNT_MAX) return ST_COUNT;
      refs[e]++;
      return ST_OK;
    endfunction

    function logic [1:0] count_down(int e);
      if (refs[e] == 8'd0) return ST_COUNT;
      refs[e]--;
      return ST_OK;
    endfunction

    // advance the mirror by one request and return the result it must produce
    function out_t apply(in_t req);
      out_t r;
      bit   found;
      bit   have;
      int   sel;
      r = '0;
      r.status = ST_OK;
      found = 1'b0;
      have = 1'b0;
      sel = 0;
      case (req.op)
        OP_GET: begin
          // first matching tag wins, free or not
          foreach (in_use[e]) begin
            if (!found && in_use[e] && tag_dev[e] == req.device &&
                tag_blk[e] == req.block_number) begin
              found = 1'b1;
              sel = e;
            end
          end
          if (found) begin
            r.hit = 1'b1;
            r.status = count_up(sel);
          end else begin
            // victim: free entry with the oldest fill tick, lowest index on ties
            foreach (refs[e]) begin
              if (refs[e] == 8'd0 && (!have || filled_at[e] < filled_at[sel])) begin
                have = 1'b1;
                sel = e;
              end
            end
            if (have) begin
              in_use[sel]    = 1'b1;
              tag_dev[sel]   = req.device;
              tag_blk[sel]   = req.block_number;
              refs[sel]      = 8'd1;
              loaded[sel]    = 1'b0;
              filled_at[sel] = req.now_tick;
              found = 1'b1;
            end else begin
              r.status = ST_NOBUF;
            end
          end
          if (found) begin
            r.result_entry = 5'(sel);
            r.needs_read = !loaded[sel];
            loaded[sel] = 1'b1;
          end
        end
        OP_PIN:  r.status = count_up(int'(req.entry_index));
        default: r.status = count_down(int'(req.entry_index));
      endcase
      return r;
    endfunction

    function void note_request(in_t req);
      owed_q.push_back(apply(req));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed_q.size() == 0) begin
        $error("result %h with no request outstanding", got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("result_entry", 32'(want.result_entry), 32'(got.result_entry));
      check_field("hit", 32'(want.hit), 32'(got.hit));
      check_field("needs_read", 32'(want.needs_read), 32'(got.needs_read));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // random entry with a nonzero count, or -1 when all are free
    function int pick_pinned();
      int cand[$];
      foreach (refs[e]) if (refs[e] != 8'd0) cand.push_back(e);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function int pick_in_use();
      int cand[$];
      foreach (in_use[e]) if (in_use[e]) cand.push_back(e);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  tag_store_scoreboard sb = new();

  // small tag pool so gets hit often and overfill the 32 entries
  bit [7:0]  dev_pool [4] = '{8'h00, 8'hFF, 8'h3C, 8'hC3};
  bit [31:0] blk_pool [12];
  bit [31:0] tick_now;

  int issued;      // transactions accepted on the request side
  int burst_left;  // back-to-back transactions left before the next gap
  int hold_asked;  // long receiver hold-offs requested by the sender
  int hold_served;
  int hold_left;
  int stall_mode;
  int stall_mode_left;
  int cycles;

  always #5 clk = ~clk;

  block_buffer_cache_tags #(
    .NUM_ENTRIES(ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // watchdog: a hang or a lost result ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("block_buffer_cache_tags regression: fail");
      $finish;
    end
  end

  // result side: check every transaction, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      // long hold-off: results back up and the block stalls its input
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(3);
        stall_mode_left = $urandom_range(10, 150);
      end
      stall_mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;                       // open stretch
        1:       out_stall <= ($urandom_range(99) < 25);  // light stalls
        2:       out_stall <= ($urandom_range(99) < 75);  // heavy stalls
        default: out_stall <= ~out_stall;                 // alternating stall and no stall
      endcase
    end
  end

  // present one transaction and hold it until the block takes it;
  // called and returns just after a rising edge
  task automatic send(input in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    issued++;
  endtask

  // send, then end the burst with a random gap when it runs out
  task automatic issue(input in_t req);
    send(req);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // occasional long bursts give stretches with no sender idling
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  function automatic in_t make_get(bit [7:0] dev, bit [31:0] blk, bit [31:0] tick);
    in_t r;
    r = '0;
    r.op = OP_GET;
    r.device = dev;
    r.block_number = blk;
    r.now_tick = tick;
    return r;
  endfunction

  function automatic in_t make_count(logic [1:0] op, bit [4:0] idx);
    in_t r;
    r = '0;
    r.op = op;
    r.entry_index = idx;
    return r;
  endfunction

  // mostly creeping ticks with ties, now and then a jump anywhere
  function automatic bit [31:0] next_tick();
    if ($urandom_range(99) < 15) tick_now = $urandom;
    else tick_now += $urandom_range(0, 3);
    return tick_now;
  endfunction

  function automatic in_t random_get();
    in_t r;
    r = make_get(8'h00, 32'h0, next_tick());
    if ($urandom_range(99) < 80) begin
      r.device = dev_pool[$urandom_range(3)];
      r.block_number = blk_pool[$urandom_range(11)];
    end else begin
      r.device = 8'($urandom);
      r.block_number = $urandom;
    end
    r.entry_index = 5'($urandom);  // ignored by a get
    return r;
  endfunction

  // count change, usually aimed at a pinned entry so the count really moves
  function automatic in_t random_count(logic [1:0] op);
    in_t r;
    int  target;
    int  aim;
    aim = (op == OP_PIN) ? 60 : 75;
    target = sb.pick_pinned();
    r = make_count(op, 5'($urandom));
    if (target >= 0 && $urandom_range(99) < aim) r.entry_index = 5'(target);
    r.device = 8'($urandom);  // don't-care fields still toggle
    r.block_number = $urandom;
    r.now_tick = $urandom;
    return r;
  endfunction

  // pin one cached entry up to saturation, overflow it by pin and by get,
  // then release it all the way down and underflow it
  task automatic saturation_walk();
    int e;
    e = sb.pick_in_use();
    if (e < 0) e = 0;
    while (sb.refs[e] != COUNT_MAX) issue(make_count(OP_PIN, 5'(e)));
    repeat (2) issue(make_count(OP_PIN, 5'(e)));
    if (sb.in_use[e]) issue(make_get(sb.tag_dev[e], sb.tag_blk[e], next_tick()));
    while (sb.refs[e] != 8'd0) issue(make_count(OP_RELEASE, 5'(e)));
    issue(make_count(OP_UNPIN, 5'(e)));
  endtask

  initial begin
    in_t directed[$];
    int  stop_at;
    int  fill_left;
    bit  fill_phase;
    bit  walked;
    int  holds_done;
    int  pct;

    blk_pool[0] = 32'h0000_0000;
    blk_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) blk_pool[i] = $urandom;

    // directed part: extreme tags and ticks, every op and the corner cases
    directed.push_back(make_get(8'h00, 32'h0000_0000, 32'h0000_0000));  // cold miss, entry 0
    directed.push_back(make_get(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));  // cold miss, entry 1
    directed.push_back(make_get(8'h00, 32'h0000_0000, 32'h0000_0010));  // hit, already loaded
    directed.push_back(make_count(OP_PIN, 5'd0));
    repeat (3) directed.push_back(make_count(OP_RELEASE, 5'd0));       // down to zero
    directed.push_back(make_count(OP_RELEASE, 5'd0));                  // underflow on release
    directed.push_back(make_count(OP_UNPIN, 5'd0));                    // underflow on unpin
    directed.push_back(make_get(8'h00, 32'h0000_0000, 32'h0000_0020));  // hit on a free entry
    directed.push_back(make_count(OP_UNPIN, 5'd0));
    directed.push_back(make_get(8'h12, 32'h0000_0034, 32'h0000_0000));  // tick tie, evicts entry 0
    directed.push_back(make_get(8'h00, 32'h0000_0000, 32'h0000_0005));  // old tag now misses
    directed.push_back(make_count(OP_PIN, 5'd31));                     // count on an unused entry
    directed.push_back(make_count(OP_UNPIN, 5'd31));
    directed.push_back(make_count(OP_RELEASE, 5'd31));                 // underflow, unused entry
    directed.push_back(make_count(OP_RELEASE, 5'd1));                  // entry 1 free, newest tick
    directed.push_back(make_get(8'hAB, 32'h8000_0000, 32'h0000_0007));  // oldest free wins
    directed.push_back(make_get(8'hFF, 32'hFFFF_FFFF, 32'h0000_0009));  // hit on free, no read
    directed.push_back(make_count(OP_PIN, 5'd31));
    directed.push_back(make_count(OP_RELEASE, 5'd31));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) issue(directed[i]);

    // random part: fill phases drive the store to no free buffer,
    // drain phases release entries so misses find victims again
    stop_at = issued + RANDOM_ITEMS;
    fill_left = 0;
    fill_phase = 1'b0;
    walked = 1'b0;
    holds_done = 0;
    while (issued < stop_at) begin
      if (holds_done < 2 && issued >= stop_at - RANDOM_ITEMS + 100 + 800 * holds_done) begin
        holds_done++;
        hold_asked++;
      end
      if (!walked && issued >= stop_at - RANDOM_ITEMS + 300) begin
        walked = 1'b1;
        saturation_walk();
      end
      if (fill_left == 0) begin
        fill_phase = !fill_phase;
        fill_left = $urandom_range(60, 150);
      end
      fill_left--;
      pct = $urandom_range(99);
      if (fill_phase) begin
        if (pct < 65)      issue(random_get());
        else if (pct < 75) issue(random_count(OP_PIN));
        else if (pct < 90) issue(random_count(OP_RELEASE));
        else               issue(random_count(OP_UNPIN));
      end else begin
        if (pct < 30)      issue(random_get());
        else if (pct < 35) issue(random_count(OP_PIN));
        else if (pct < 80) issue(random_count(OP_RELEASE));
        else               issue(random_count(OP_UNPIN));
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // watch for stray results after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("block_buffer_cache_tags regression: pass");
    end else begin
      $display("block_buffer_cache_tags regression: fail");
    end
    $finish;
  end

endmodule
